// ===== rtl/avccfg_pkg.sv =====
// Shared constants for the FLV AVC sequence header builder.
`default_nettype none
package avccfg_pkg;

  // Result status codes.
  localparam logic [1:0] ST_VALID     = 2'd0;
  localparam logic [1:0] ST_NO_RECORD = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  // Header constants.
  localparam logic [7:0] HDR_TAG        = 8'h17;
  localparam logic [7:0] CFG_VERSION    = 8'h01;
  localparam logic [7:0] LEN_SIZE_BYTE  = 8'hFF;
  localparam logic [7:0] SPS_COUNT_BYTE = 8'hE1;
  localparam logic [7:0] PPS_COUNT_BYTE = 8'h01;
  localparam logic [7:0] SC_FINAL_BYTE  = 8'h01;

  // NAL unit type field.
  localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
  localparam logic [4:0] NAL_SPS       = 5'h07;
  localparam logic [4:0] NAL_PPS       = 5'h08;

endpackage
`default_nettype wire

// ===== rtl/avccfg_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module avccfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/annexb_to_avc_config_record.sv =====
// Top level of the FLV AVC sequence header builder.
// Load transactions (action 0) write one Annex-B extradata byte per accepted cycle
// into a BUF_BYTES byte buffer while start codes are tracked on the fly; they
// produce no result. After the byte flagged last_byte, the block steps through
// PH_RD0, PH_RD1, PH_CLS2 and PH_CHECK, classifying the first two units, reading
// their first bytes one at a time through the buffer's single read port, and takes
// no transaction meanwhile. Fetch transactions (action 1) then return the sequence
// header one byte per cycle while the output drains; the read port is kept one byte
// ahead of the fetch index so that buffer bytes come out without a bubble. A fetch
// while loading or after the record is complete returns status 2; a missing SPS or
// PPS, an SPS shorter than four bytes or an overflowing load gives a single status 1
// result. A load after a completed load starts over. Results wait in an output
// register; outside those phases, input is taken when it is empty or draining.
`default_nettype none
module annexb_to_avc_config_record #(
  parameter int BUF_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       action,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic [1:0]      status
);

  import avccfg_pkg::*;

  localparam int AW = $clog2(BUF_BYTES);
  localparam int PW = $clog2(BUF_BYTES + 1);
  localparam int EW = PW + 2;

  localparam logic [2:0] PH_LOAD  = 3'd0;
  localparam logic [2:0] PH_RD0   = 3'd1;
  localparam logic [2:0] PH_RD1   = 3'd2;
  localparam logic [2:0] PH_CLS2  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;
  localparam logic [2:0] PH_EMIT  = 3'd5;
  localparam logic [2:0] PH_ERROR = 3'd6;
  localparam logic [2:0] PH_DONE  = 3'd7;

  logic [2:0]    phase;
  logic [PW-1:0] load_count;
  logic [1:0]    zero_run;
  logic [PW-1:0] pos [3];
  logic [1:0]    scs;
  logic [PW-1:0] sps_lo, sps_hi, pps_lo, pps_hi;
  logic          overflow;
  logic [EW-1:0] emit_index;

  logic          fire, load_fire, fetch_fire, fresh, busy, we, is_sc;
  logic [PW-1:0] cnt_eff;
  logic [1:0]    zr_eff, scs_eff;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  logic [PW-1:0] slen, plen;
  logic [EW-1:0] slen_e, plen_e, total_e, emit_inc, idx_rd, addr_full;
  logic [7:0]    hdr_byte;
  logic [15:0]   slen16, plen16;

  logic          u1_ok, u2_ok, err;
  logic [PW-1:0] u1_end, u2_end;
  logic [4:0]    kind;

  assign busy = (phase == PH_RD0) || (phase == PH_RD1) || (phase == PH_CLS2)
             || (phase == PH_CHECK);
  assign in_ready   = !busy && (!out_valid || out_ready);
  assign fire       = in_valid && in_ready;
  assign load_fire  = fire && !action;
  assign fetch_fire = fire && action;

  // A load arriving after a finished load starts from a cleared state.
  assign fresh   = (phase != PH_LOAD);
  assign cnt_eff = fresh ? '0 : load_count;
  assign zr_eff  = fresh ? 2'd0 : zero_run;
  assign scs_eff = fresh ? 2'd0 : scs;
  assign we      = load_fire && (cnt_eff < PW'(BUF_BYTES));
  assign is_sc   = (data_byte == SC_FINAL_BYTE) && (zr_eff == 2'd3) && (scs_eff < 2'd3);

  assign slen     = sps_hi - sps_lo;
  assign plen     = pps_hi - pps_lo;
  assign slen_e   = EW'(slen);
  assign plen_e   = EW'(plen);
  assign total_e  = EW'(16) + slen_e + plen_e;
  assign emit_inc = emit_index + EW'(1);
  assign slen16   = 16'(slen);
  assign plen16   = 16'(plen);

  // Outside PH_RD0 and PH_RD1 the read port points at the byte needed by the next fetch.
  assign idx_rd = (fetch_fire && phase == PH_EMIT) ? emit_inc : emit_index;

  always_comb begin
    if (idx_rd < EW'(9)) begin
      addr_full = EW'(sps_lo) + idx_rd - EW'(5);
    end else if (idx_rd < EW'(13) + slen_e) begin
      addr_full = EW'(sps_lo) + idx_rd - EW'(13);
    end else begin
      addr_full = EW'(pps_lo) + idx_rd - EW'(16) - slen_e;
    end
  end

  always_comb begin
    unique case (phase)
      PH_RD0:  raddr = pos[0][AW-1:0];
      PH_RD1:  raddr = pos[1][AW-1:0];
      default: raddr = addr_full[AW-1:0];
    endcase
  end

  avccfg_ram #(
    .WIDTH(8),
    .DEPTH(BUF_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(cnt_eff[AW-1:0]),
    .wdata(data_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    if (emit_index == EW'(0)) begin
      hdr_byte = HDR_TAG;
    end else if (emit_index <= EW'(4)) begin
      hdr_byte = 8'h00;
    end else if (emit_index == EW'(5)) begin
      hdr_byte = CFG_VERSION;
    end else if (emit_index <= EW'(8)) begin
      hdr_byte = rdata;
    end else if (emit_index == EW'(9)) begin
      hdr_byte = LEN_SIZE_BYTE;
    end else if (emit_index == EW'(10)) begin
      hdr_byte = SPS_COUNT_BYTE;
    end else if (emit_index == EW'(11)) begin
      hdr_byte = slen16[15:8];
    end else if (emit_index == EW'(12)) begin
      hdr_byte = slen16[7:0];
    end else if (emit_index < EW'(13) + slen_e) begin
      hdr_byte = rdata;
    end else if (emit_index == EW'(13) + slen_e) begin
      hdr_byte = PPS_COUNT_BYTE;
    end else if (emit_index == EW'(14) + slen_e) begin
      hdr_byte = plen16[15:8];
    end else if (emit_index == EW'(15) + slen_e) begin
      hdr_byte = plen16[7:0];
    end else begin
      hdr_byte = rdata;
    end
  end

  // Unit bounds: the byte after each start code, ending four bytes before the next.
  assign u1_end = pos[1] - PW'(4);
  assign u2_end = (scs == 2'd3) ? (pos[2] - PW'(4)) : load_count;
  assign u1_ok  = (scs >= 2'd2) && (pos[0] < u1_end) && (pos[0] < PW'(BUF_BYTES));
  assign u2_ok  = (scs >= 2'd2) && (pos[1] < u2_end) && (pos[1] < PW'(BUF_BYTES));
  assign kind   = rdata[4:0] & NAL_TYPE_MASK;
  assign err    = overflow || (slen < PW'(4)) || (pps_hi == pps_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LOAD;
      load_count <= '0;
      zero_run   <= '0;
      pos[0]     <= '0;
      pos[1]     <= '0;
      pos[2]     <= '0;
      scs        <= '0;
      sps_lo     <= '0;
      sps_hi     <= '0;
      pps_lo     <= '0;
      pps_hi     <= '0;
      overflow   <= 1'b0;
      emit_index <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (load_fire) begin
        if (fresh) begin
          sps_lo     <= '0;
          sps_hi     <= '0;
          pps_lo     <= '0;
          pps_hi     <= '0;
          emit_index <= '0;
          pos[0]     <= '0;
          pos[1]     <= '0;
          pos[2]     <= '0;
        end
        overflow   <= (!fresh && overflow) || !we;
        load_count <= we ? (cnt_eff + PW'(1)) : cnt_eff;
        if (we) begin
          if (data_byte == 8'h00) begin
            zero_run <= (zr_eff == 2'd3) ? 2'd3 : (zr_eff + 2'd1);
          end else begin
            zero_run <= 2'd0;
          end
          if (is_sc) begin
            pos[scs_eff] <= cnt_eff + PW'(1);
            scs          <= scs_eff + 2'd1;
          end else begin
            scs <= scs_eff;
          end
        end else begin
          zero_run <= zr_eff;
          scs      <= scs_eff;
        end
        phase <= last_byte ? PH_RD0 : PH_LOAD;
      end else if (fetch_fire) begin
        out_valid <= 1'b1;
        out_byte  <= 8'h00;
        out_last  <= 1'b0;
        status    <= ST_NOT_READY;
        if (phase == PH_ERROR) begin
          out_last <= 1'b1;
          status   <= ST_NO_RECORD;
          phase    <= PH_DONE;
        end else if (phase == PH_EMIT) begin
          out_byte   <= hdr_byte;
          status     <= ST_VALID;
          emit_index <= emit_inc;
          if (emit_inc >= total_e) begin
            out_last <= 1'b1;
            phase    <= PH_DONE;
          end
        end
      end else begin
        unique case (phase)
          PH_RD0: begin
            phase <= PH_RD1;
          end
          PH_RD1: begin
            if (u1_ok && kind == NAL_SPS) begin
              sps_lo <= pos[0];
              sps_hi <= u1_end;
            end else if (u1_ok && kind == NAL_PPS) begin
              pps_lo <= pos[0];
              pps_hi <= u1_end;
            end
            phase <= PH_CLS2;
          end
          PH_CLS2: begin
            if (u2_ok && kind == NAL_SPS) begin
              sps_lo <= pos[1];
              sps_hi <= u2_end;
            end else if (u2_ok && kind == NAL_PPS) begin
              pps_lo <= pos[1];
              pps_hi <= u2_end;
            end
            phase <= PH_CHECK;
          end
          PH_CHECK: begin
            phase      <= err ? PH_ERROR : PH_EMIT;
            emit_index <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/avccfg_chk.sv =====
// Port-level checker for the sequence header builder, bound to the top level.
`default_nettype none
module avccfg_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       action,
  input wire logic [7:0] data_byte,
  input wire logic       last_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last,
  input wire logic [1:0] status
);

  import avccfg_pkg::*;

  // A result that is not taken stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(status))
    else $error("stalled result changed");

  // Status results other than a valid byte carry a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_VALID |-> out_byte == 8'h00)
    else $error("nonzero byte on status result");

  // The error result always closes the record, and "nothing ready" never does.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_RECORD || status == ST_NOT_READY)
      |-> out_last == (status == ST_NO_RECORD))
    else $error("out_last wrong on status result");

endmodule

bind annexb_to_avc_config_record avccfg_chk u_avccfg_chk (.*);
`default_nettype wire

// ===== dv/avc_record_tb_pkg.sv =====
// Testbench-wide codes for the AVC sequence header builder environment.
package avc_record_tb_pkg;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_FETCH = 1'b1
  } avc_action_e;

endpackage

// ===== dv/avc_record_checker.sv =====
// Watches both channels of the AVC sequence header builder, predicts each result and compares.
module avc_record_checker
  import avccfg_pkg::*;
  import avc_record_tb_pkg::*;
#(
  parameter int BUF_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic       action,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_byte,
  input  wire logic       out_last,
  input  wire logic [1:0] status,
  output int              mismatch_count,
  output int              results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = $clog2(BUF_BYTES) + 1;

  typedef enum logic [1:0] {
    REC_LOADING,
    REC_EMIT,
    REC_ERROR,
    REC_DONE
  } rec_phase_e;

  typedef struct packed {
    logic [7:0] hdr_byte;
    logic       last;
    logic [1:0] st;
  } hdr_beat_t;

  logic [7:0]    nal_bytes [BUF_BYTES];
  logic [PW-1:0] bytes_loaded;
  logic [1:0]    zero_count;
  logic [PW-1:0] unit_start [3];
  logic [1:0]    codes_found;
  logic [PW-1:0] sps_lo, sps_hi, pps_lo, pps_hi;
  logic          too_long;
  rec_phase_e    rec_phase;
  logic [9:0]    emit_pos;
  hdr_beat_t     header_bytes_due [$];
  int            beats_seen;

  function automatic void start_new_load();
    bytes_loaded = '0;
    zero_count   = '0;
    foreach (unit_start[n]) unit_start[n] = '0;
    codes_found  = '0;
    sps_lo       = '0;
    sps_hi       = '0;
    pps_lo       = '0;
    pps_hi       = '0;
    too_long     = 1'b0;
    rec_phase    = REC_LOADING;
    emit_pos     = '0;
  endfunction

  // A unit with no bytes has no type and leaves the bounds alone.
  function automatic void note_unit(input int unsigned first, input int unsigned stop);
    logic [4:0] kind;
    if (first >= stop || first >= BUF_BYTES) return;
    kind = nal_bytes[first][4:0] & NAL_TYPE_MASK;
    if (kind == NAL_SPS) begin
      sps_lo = PW'(first);
      sps_hi = PW'(stop);
    end else if (kind == NAL_PPS) begin
      pps_lo = PW'(first);
      pps_hi = PW'(stop);
    end
  endfunction

  function automatic void close_extradata();
    int unsigned second_end;
    if (codes_found >= 2) begin
      note_unit(unit_start[0], unit_start[1] - 4);
      second_end = (codes_found >= 3) ? unit_start[2] - 4 : bytes_loaded;
      note_unit(unit_start[1], second_end);
    end
    if (too_long || (sps_hi - sps_lo) < 4 || pps_hi == pps_lo) begin
      rec_phase = REC_ERROR;
    end else begin
      rec_phase = REC_EMIT;
    end
    emit_pos = '0;
  endfunction

  function automatic void take_extradata(input logic [7:0] value, input logic final_flag);
    if (rec_phase != REC_LOADING) start_new_load();
    if (bytes_loaded >= BUF_BYTES) begin
      too_long = 1'b1;
    end else begin
      nal_bytes[bytes_loaded] = value;
      if (value == 8'h00) begin
        if (zero_count < 3) zero_count++;
      end else begin
        // Longer zero runs still count; only the first three codes are kept.
        if (value == SC_FINAL_BYTE && zero_count == 3 && codes_found < 3) begin
          unit_start[codes_found] = bytes_loaded + PW'(1);
          codes_found++;
        end
        zero_count = '0;
      end
      bytes_loaded++;
    end
    if (final_flag) close_extradata();
  endfunction

  function automatic logic [7:0] record_byte(input int unsigned i, input int unsigned slen,
                                             input int unsigned plen);
    if (i == 0) return HDR_TAG;
    if (i <= 4) return 8'h00;
    if (i == 5) return CFG_VERSION;
    if (i <= 8) return nal_bytes[(sps_lo + i - 5) % BUF_BYTES];
    if (i == 9) return LEN_SIZE_BYTE;
    if (i == 10) return SPS_COUNT_BYTE;
    if (i == 11) return 8'(slen >> 8);
    if (i == 12) return 8'(slen);
    if (i < 13 + slen) return nal_bytes[(sps_lo + i - 13) % BUF_BYTES];
    if (i == 13 + slen) return PPS_COUNT_BYTE;
    if (i == 14 + slen) return 8'(plen >> 8);
    if (i == 15 + slen) return 8'(plen);
    return nal_bytes[(pps_lo + i - 16 - slen) % BUF_BYTES];
  endfunction

  function automatic hdr_beat_t fetch_header_byte();
    hdr_beat_t   beat;
    int unsigned slen, plen, total;
    beat = '{hdr_byte: 8'h00, last: 1'b0, st: ST_NOT_READY};
    if (rec_phase == REC_ERROR) begin
      beat.last = 1'b1;
      beat.st   = ST_NO_RECORD;
      rec_phase = REC_DONE;
    end else if (rec_phase == REC_EMIT) begin
      slen  = sps_hi - sps_lo;
      plen  = pps_hi - pps_lo;
      total = 16 + slen + plen;
      beat.hdr_byte = record_byte(emit_pos, slen, plen);
      beat.st       = ST_VALID;
      emit_pos++;
      if (emit_pos >= total) begin
        beat.last = 1'b1;
        rec_phase = REC_DONE;
      end
    end
    return beat;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    hdr_beat_t due;
    if (rst) begin
      start_new_load();
      header_bytes_due.delete();
      beats_seen = 0;
    end else begin
      // Results are checked before new fetches are queued: a result leaving at this
      // edge can never belong to a fetch taken at the same edge.
      if (out_valid && out_ready) begin
        if (header_bytes_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d (byte %02h status %0d) with nothing expected",
                                  beats_seen, out_byte, status));
        end else begin
          due = header_bytes_due.pop_front();
          if (out_byte !== due.hdr_byte)
            flag_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
                                    beats_seen, out_byte, due.hdr_byte));
          if (out_last !== due.last)
            flag_mismatch($sformatf("result %0d out_last %0b, expected %0b",
                                    beats_seen, out_last, due.last));
          if (status !== due.st)
            flag_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    beats_seen, status, due.st));
        end
        beats_seen++;
      end
      if (in_valid && in_ready) begin
        if (action == ACT_LOAD) take_extradata(data_byte, last_byte);
        else header_bytes_due.push_back(fetch_header_byte());
      end
    end
    results_due <= header_bytes_due.size();
  end

endmodule

// ===== dv/annexb_to_avc_config_record_test.sv =====
// Testbench top for the AVC sequence header builder: stimulus, flow control and verdict.
module annexb_to_avc_config_record_test;
  timeunit 1ns;
  timeprecision 1ps;

  import avccfg_pkg::*;
  import avc_record_tb_pkg::*;

  localparam int BUF_BYTES     = 256;
  localparam int ITEM_TARGET   = 1750;
  localparam int SILENCE_LIMIT = 2000;
  localparam int HOLD_CYCLES   = 80;

  typedef enum int {
    SH_WELL_FORMED,
    SH_NO_PAIR,
    SH_SHORT_SPS,
    SH_OVERFLOW,
    SH_NOISE,
    SH_ONE_CODE,
    SH_EMPTY_UNIT,
    SH_FULL_BUFFER
  } stream_shape_e;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       action    = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_ready = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [7:0] out_byte;
  wire        out_last;
  wire  [1:0] status;

  int         mismatch_count;
  int         results_due;
  int         items_sent    = 0;
  int         quiet_cycles  = 0;
  bit         sender_rush   = 1'b0;
  bit         receiver_rush = 1'b0;
  logic [7:0] annexb [$];

  always #1 clk = ~clk;

  annexb_to_avc_config_record #(
    .BUF_BYTES (BUF_BYTES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .status    (status)
  );

  avc_record_checker #(
    .BUF_BYTES (BUF_BYTES)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .status         (status),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= SILENCE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", SILENCE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic put_item(input avc_action_e act, input logic [7:0] value,
                          input logic final_flag);
    int gap;
    if ($urandom_range(0, 39) == 0) sender_rush = ~sender_rush;
    gap = sender_rush ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= value;
    last_byte <= final_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [7:0] nal_header(input logic [4:0] kind);
    return {3'($urandom_range(0, 7)), kind};
  endfunction

  function automatic logic [4:0] filler_kind();
    logic [4:0] kind;
    do kind = 5'($urandom_range(0, 31)); while (kind == NAL_SPS || kind == NAL_PPS);
    return kind;
  endfunction

  task automatic push_start_code(input int extra_zeros);
    repeat (extra_zeros + 3) annexb.push_back(8'h00);
    annexb.push_back(SC_FINAL_BYTE);
  endtask

  task automatic push_unit(input logic [4:0] kind, input int len);
    annexb.push_back(nal_header(kind));
    for (int n = 1; n < len; n++)
      annexb.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
  endtask

  task automatic send_extradata();
    foreach (annexb[n]) begin
      // Now and then a fetch lands in the middle of a load.
      if ($urandom_range(0, 29) == 0) put_item(ACT_FETCH, 8'($urandom), 1'($urandom));
      put_item(ACT_LOAD, annexb[n], n == annexb.size() - 1);
    end
  endtask

  task automatic fetch_bytes(input int count);
    repeat (count) put_item(ACT_FETCH, 8'($urandom), 1'($urandom));
  endtask

  task automatic run_extradata_case();
    stream_shape_e shape;
    int            sps_len, pps_len, pad1, pad2, record_len, pick;
    logic [4:0]    kind_a, kind_b, absent;
    annexb.delete();
    if ($urandom_range(0, 15) < 9) shape = SH_WELL_FORMED;
    else shape = stream_shape_e'($urandom_range(1, 7));
    sps_len    = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 180) : $urandom_range(4, 24);
    pps_len    = $urandom_range(1, 12);
    pad1       = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    record_len = 0;
    case (shape)
      SH_WELL_FORMED, SH_SHORT_SPS: begin
        if (shape == SH_SHORT_SPS) sps_len = $urandom_range(1, 3);
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 3)) annexb.push_back(8'($urandom_range(1, 255)));
        push_start_code(($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        // Zeros ahead of the next start code belong to the unit before it.
        if ($urandom_range(0, 1) == 0) begin
          push_unit(NAL_SPS, sps_len);
          push_start_code(pad1);
          push_unit(NAL_PPS, pps_len);
        end else begin
          push_unit(NAL_PPS, pps_len);
          push_start_code(pad1);
          push_unit(NAL_SPS, sps_len);
        end
        record_len = 16 + sps_len + pps_len + pad1;
        if ($urandom_range(0, 2) == 0) begin
          pad2 = $urandom_range(0, 2);
          push_start_code(pad2);
          push_unit(5'($urandom_range(0, 31)), $urandom_range(1, 6));
          record_len += pad2;
        end
      end
      SH_NO_PAIR: begin
        absent = ($urandom_range(0, 1) == 0) ? NAL_SPS : NAL_PPS;
        kind_a = ($urandom_range(0, 1) == 0) ? filler_kind() : NAL_SPS ^ NAL_PPS ^ absent;
        kind_b = ($urandom_range(0, 1) == 0) ? filler_kind() : NAL_SPS ^ NAL_PPS ^ absent;
        push_start_code(0);
        push_unit(kind_a, sps_len);
        push_start_code(pad1);
        push_unit(kind_b, pps_len);
      end
      SH_OVERFLOW: begin
        // From one to twenty-one bytes past the buffer.
        pps_len = $urandom_range(1, 10);
        sps_len = 249 - pps_len + $urandom_range(0, 20);
        push_start_code(0);
        push_unit(NAL_SPS, sps_len);
        push_start_code(0);
        push_unit(NAL_PPS, pps_len);
      end
      SH_NOISE: begin
        repeat ($urandom_range(1, 40)) begin
          pick = $urandom_range(0, 7);
          if (pick < 4) annexb.push_back(8'h00);
          else if (pick < 6) annexb.push_back(SC_FINAL_BYTE);
          else if (pick == 6) annexb.push_back(nal_header($urandom_range(0, 1) ? NAL_SPS : NAL_PPS));
          else annexb.push_back(8'($urandom));
        end
      end
      SH_ONE_CODE: begin
        push_start_code(pad1);
        push_unit(NAL_SPS, sps_len);
      end
      SH_EMPTY_UNIT: begin
        case ($urandom_range(0, 2))
          0: begin
            push_start_code(0);
            push_start_code(0);
            push_unit(NAL_SPS, sps_len);
            push_start_code(0);
            push_unit(NAL_PPS, pps_len);
          end
          1: begin
            push_start_code(0);
            push_unit(NAL_SPS, sps_len);
            push_start_code(0);
          end
          default: begin
            push_start_code(0);
            push_unit(NAL_PPS, pps_len);
            push_start_code(0);
            push_start_code(0);
            push_unit(NAL_SPS, sps_len);
          end
        endcase
      end
      default: begin
        // Exactly fills the buffer.
        pps_len = $urandom_range(1, 10);
        sps_len = 248 - pps_len;
        push_start_code(0);
        push_unit(NAL_SPS, sps_len);
        push_start_code(0);
        push_unit(NAL_PPS, pps_len);
        record_len = 16 + sps_len + pps_len;
      end
    endcase
    send_extradata();
    if (record_len == 0) begin
      fetch_bytes((shape == SH_NOISE) ? $urandom_range(1, 30) : $urandom_range(1, 3));
    end else if ($urandom_range(0, 7) == 0) begin
      // Abandon the record part way so that the next load starts over.
      fetch_bytes($urandom_range(0, record_len - 1));
    end else begin
      fetch_bytes(record_len + $urandom_range(0, 2));
    end
  endtask

  initial begin : result_drain
    int gap;
    int taken;
    taken = 0;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 39) == 0) receiver_rush = ~receiver_rush;
      gap = receiver_rush ? 0 : $urandom_range(0, 17);
      // Long back-pressure while the sender keeps going, so the block stalls its input.
      if ((taken % 200) == 150) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int waited;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    put_item(ACT_FETCH, 8'hA5, 1'b1);  // nothing loaded yet
    put_item(ACT_LOAD, 8'h00, 1'b1);   // lone zero: no start code, so no record
    put_item(ACT_FETCH, 8'h00, 1'b0);
    put_item(ACT_FETCH, 8'hFF, 1'b0);  // error already given
    put_item(ACT_LOAD, 8'hFF, 1'b0);   // a new load clears the finished one
    put_item(ACT_FETCH, 8'h5A, 1'b1);  // still loading
    put_item(ACT_LOAD, 8'h01, 1'b1);
    put_item(ACT_FETCH, 8'h00, 1'b0);

    while (items_sent < ITEM_TARGET) run_extradata_case();
    in_valid <= 1'b0;

    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (results_due != 0 && waited < 20000);
    repeat (40) @(posedge clk);

    if (mismatch_count == 0 && results_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      if (results_due != 0) $display("%0d expected results never arrived", results_due);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
